### rtl/trl_pkg.sv
// shared types and constants of the tunnel replication lookup block
`default_nettype none

package trl_pkg;

	// width of call, tunnel and interface ids
	localparam int ID_W = 10;

	// command codes
	typedef enum logic [2:0] {
		CMD_PACKET = 3'd0,
		CMD_IFACE  = 3'd1,
		CMD_TUNNEL = 3'd2,
		CMD_KIND   = 3'd3,
		CMD_SLOT   = 3'd4
	} trl_cmd_t;

	// call type codes
	localparam logic [1:0] KIND_OTHER = 2'd0;
	localparam logic [1:0] KIND_SRB   = 2'd1;
	localparam logic [1:0] KIND_DRB   = 2'd2;

	// one tunnel slot entry
	typedef struct packed {
		logic            valid;
		logic [ID_W-1:0] id;
	} trl_entry_t;

	// fixed part of a walk descriptor: fallback result and rx iface rewrite
	typedef struct packed {
		logic            rxw;
		logic            write;
		logic            inval;
		logic [ID_W-1:0] tun;
	} trl_fixed_t;

endpackage

`default_nettype wire

### rtl/trl_front.sv
// front part: table storage, call lookup and walk descriptor build
`default_nettype none

module trl_front #(
	parameter int SLOTS   = 4,
	parameter int CALLS   = 1024,
	parameter int TUNNELS = 1024,
	parameter int IFACES  = 1024
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic [2:0]                             command,
	input  wire logic                                   rx_tunnel_valid,
	input  wire logic [trl_pkg::ID_W-1:0]               rx_tunnel,
	input  wire logic                                   call_hint_valid,
	input  wire logic [trl_pkg::ID_W-1:0]               call_hint,
	input  wire logic [trl_pkg::ID_W-1:0]               tx_iface,
	input  wire logic [7:0]                             path_count,
	input  wire logic [7:0]                             path_slots,
	input  wire logic [trl_pkg::ID_W-1:0]               table_index,
	input  wire logic [1:0]                             slot_index,
	input  wire logic [trl_pkg::ID_W-1:0]               write_value,
	input  wire logic                                   write_valid,
	input  wire logic                                   q_full,
	output logic                                        push,
	output logic [SLOTS-1:0]                            desc_mask,
	output logic [SLOTS-1:0][trl_pkg::ID_W-1:0]         desc_tun,
	output trl_pkg::trl_fixed_t                         desc_fixed
);
	import trl_pkg::*;

	localparam int IAW = (IFACES > 1) ? $clog2(IFACES) : 1;
	localparam int TAW = (TUNNELS > 1) ? $clog2(TUNNELS) : 1;
	localparam int CAW = (CALLS > 1) ? $clog2(CALLS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAP,
		ST_ROW
	} state_t;

	state_t            state_q;
	logic              clr_q;
	logic [CAW-1:0]    clr_addr_q;
	logic              acc;

	// tables
	logic [ID_W-1:0]             imap [IFACES];
	logic [ID_W-1:0]             tmap [TUNNELS];
	logic [1:0]                  kind_mem [CALLS];
	trl_entry_t [SLOTS-1:0]      slot_mem [CALLS];

	// read data and captured packet fields
	logic [ID_W-1:0]        imap_rd_q;
	logic [ID_W-1:0]        tmap_rd_q;
	logic [1:0]             kind_rd_q;
	trl_entry_t [SLOTS-1:0] row_q;
	logic                   f_ok_q;
	logic                   t_ok_q;
	logic                   call_ok_q;
	logic                   rx_tunnel_valid_q;
	logic                   call_hint_valid_q;
	logic [ID_W-1:0]        call_hint_q;
	logic [7:0]             path_count_q;
	logic [7:0]             path_slots_q;

	logic [ID_W-1:0] call;
	logic [CAW-1:0]  call_addr;
	logic            idx_iface_ok;
	logic            idx_tunnel_ok;
	logic            idx_call_ok;

	assign acc  = start && !busy;
	assign busy = clr_q || (state_q != ST_IDLE);

	assign idx_iface_ok  = 32'(table_index) < IFACES;
	assign idx_tunnel_ok = 32'(table_index) < TUNNELS;
	assign idx_call_ok   = 32'(table_index) < CALLS;

	// state, clearing pass over the call tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (clr_q) begin
				if (clr_addr_q == CAW'(CALLS - 1)) begin
					clr_q <= 1'b0;
				end
				clr_addr_q <= clr_addr_q + CAW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc && command == CMD_PACKET) begin
						state_q <= ST_MAP;
					end
				end
				ST_MAP: begin
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					if (!q_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// packet field capture
	always_ff @(posedge clk) begin
		if (acc && command == CMD_PACKET) begin
			rx_tunnel_valid_q <= rx_tunnel_valid;
			call_hint_valid_q <= call_hint_valid;
			call_hint_q       <= call_hint;
			path_count_q      <= path_count;
			path_slots_q      <= path_slots;
			f_ok_q            <= 32'(tx_iface) < IFACES;
			t_ok_q            <= 32'(rx_tunnel) < TUNNELS;
		end
		if (state_q == ST_MAP) begin
			call_ok_q <= 32'(call) < CALLS;
		end
	end

	// iface to call map
	always_ff @(posedge clk) begin
		if (acc && command == CMD_IFACE && idx_iface_ok) begin
			imap[IAW'(table_index)] <= write_value;
		end
		if (acc && command == CMD_PACKET) begin
			imap_rd_q <= imap[IAW'(tx_iface)];
		end
	end

	// tunnel to call map
	always_ff @(posedge clk) begin
		if (acc && command == CMD_TUNNEL && idx_tunnel_ok) begin
			tmap[TAW'(table_index)] <= write_value;
		end
		if (acc && command == CMD_PACKET) begin
			tmap_rd_q <= tmap[TAW'(rx_tunnel)];
		end
	end

	// call resolution from the map read data
	always_comb begin
		if (rx_tunnel_valid_q) begin
			call = t_ok_q ? tmap_rd_q : '0;
		end else if (call_hint_valid_q) begin
			call = call_hint_q;
		end else begin
			call = f_ok_q ? imap_rd_q : '0;
		end
	end

	assign call_addr = CAW'(call);

	// call type table
	always_ff @(posedge clk) begin
		if (clr_q) begin
			kind_mem[clr_addr_q] <= KIND_OTHER;
		end else if (acc && command == CMD_KIND && idx_call_ok) begin
			kind_mem[CAW'(table_index)] <= write_value[1:0];
		end
		if (state_q == ST_MAP) begin
			kind_rd_q <= kind_mem[call_addr];
		end
	end

	// slot tunnel table, one row of slots per call
	always_ff @(posedge clk) begin
		if (clr_q) begin
			slot_mem[clr_addr_q] <= '0;
		end else if (acc && command == CMD_SLOT && idx_call_ok) begin
			for (int s = 0; s < SLOTS; s++) begin
				if (int'(slot_index) == s) begin
					slot_mem[CAW'(table_index)][s] <= {write_valid, write_value};
				end
			end
		end
		if (state_q == ST_MAP) begin
			row_q <= slot_mem[call_addr];
		end
	end

	// entry of a slot id, invalid past the slot count
	function automatic trl_entry_t pick(input trl_entry_t [SLOTS-1:0] row,
			input logic [1:0] id);
		trl_entry_t e;
		e = '0;
		for (int s = 0; s < SLOTS; s++) begin
			if (int'(id) == s) begin
				e = row[s];
			end
		end
		return e;
	endfunction

	// descriptor build from call type and path info
	always_comb begin
		logic [1:0] kind;
		logic [1:0] id;
		trl_entry_t e;
		kind = call_ok_q ? kind_rd_q : KIND_OTHER;
		desc_mask        = '0;
		desc_tun         = '0;
		desc_fixed.rxw   = !rx_tunnel_valid_q && !call_hint_valid_q;
		desc_fixed.write = 1'b0;
		desc_fixed.inval = 1'b0;
		desc_fixed.tun   = '0;
		id = '0;
		e  = '0;
		if (kind == KIND_SRB && path_count_q == 8'd1) begin
			// single path: named slot, marked invalid when it is empty
			e = pick(row_q, path_slots_q[1:0]);
			desc_fixed.write = 1'b1;
			desc_fixed.inval = !e.valid;
			desc_fixed.tun   = e.valid ? e.id : '0;
		end else if (kind == KIND_SRB && path_count_q >= 8'd2 &&
				32'(path_count_q) <= SLOTS) begin
			// named walk over the carried slot ids
			for (int i = 0; i < SLOTS; i++) begin
				id = 2'(path_slots_q >> (2 * i));
				e  = pick(row_q, id);
				desc_mask[i] = (i < 4) && (i < int'(path_count_q)) && e.valid;
				desc_tun[i]  = e.id;
			end
		end else if (kind == KIND_SRB || kind == KIND_DRB) begin
			// walk over all slots
			for (int i = 0; i < SLOTS; i++) begin
				desc_mask[i] = row_q[i].valid;
				desc_tun[i]  = row_q[i].id;
			end
		end
	end

	assign push = (state_q == ST_ROW) && !q_full;

endmodule

`default_nettype wire

### rtl/trl_queue.sv
// two-entry descriptor queue between front and back parts
`default_nettype none

module trl_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  empty,
	output logic [WIDTH-1:0]      head
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full  = count_q == 2'd2;
	assign empty = count_q == 2'd0;
	assign head  = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

### rtl/trl_back.sv
// back part: walks a descriptor and emits one result per cycle while the queue is not empty
`default_nettype none

module trl_back #(
	parameter int SLOTS = 4
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 q_empty,
	input  wire logic [SLOTS-1:0]                     head_mask,
	input  wire logic [SLOTS-1:0][trl_pkg::ID_W-1:0]  head_tun,
	input  wire trl_pkg::trl_fixed_t                  head_fixed,
	output logic                                      pop,
	output logic                                      done,
	output logic                                      tx_tunnel_write,
	output logic                                      tx_tunnel_invalid,
	output logic [trl_pkg::ID_W-1:0]                  tx_tunnel,
	output logic                                      rx_iface_write,
	output logic                                      is_duplicate,
	output logic                                      last
);
	import trl_pkg::*;

	logic [1:0]       cnt_q;
	logic [SLOTS-1:0] rem_q;
	logic [SLOTS-1:0] cur;
	logic [SLOTS-1:0] low;
	logic [SLOTS-1:0] nxt;
	logic [ID_W-1:0]  tun_sel;
	logic             emit;
	logic             fin;

	// remaining slots, lowest one goes next
	assign cur  = (cnt_q == 2'd0) ? head_mask : rem_q;
	assign low  = cur & (~cur + SLOTS'(1));
	assign nxt  = cur & ~low;
	assign emit = !q_empty;
	assign fin  = (cur == '0) || (nxt == '0) || (cnt_q == 2'd3);
	assign pop  = emit && fin;

	always_comb begin
		tun_sel = '0;
		for (int s = 0; s < SLOTS; s++) begin
			if (low[s]) begin
				tun_sel = head_tun[s];
			end
		end
	end

	// walk position and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rem_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= emit;
			if (emit) begin
				if (fin) begin
					cnt_q <= 2'd0;
				end else begin
					cnt_q <= cnt_q + 2'd1;
					rem_q <= nxt;
				end
			end
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (emit) begin
			rx_iface_write <= head_fixed.rxw;
			is_duplicate   <= cnt_q != 2'd0;
			last           <= fin;
			if (cur == '0) begin
				tx_tunnel_write   <= head_fixed.write;
				tx_tunnel_invalid <= head_fixed.inval;
				tx_tunnel         <= head_fixed.tun;
			end else begin
				tx_tunnel_write   <= 1'b1;
				tx_tunnel_invalid <= 1'b0;
				tx_tunnel         <= tun_sel;
			end
		end
	end

	// a packet's results come in consecutive cycles
	a_results_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> done)
		else $error("result train broken before last");

	// copies always replace the tunnel
	a_dup_writes: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_duplicate |-> tx_tunnel_write && !tx_tunnel_invalid)
		else $error("duplicate without tunnel write");

	// invalid marker only on a single-result packet
	a_marker_single: assert property (@(posedge clk) disable iff (!arst_n)
		done && tx_tunnel_invalid |-> last && !is_duplicate && tx_tunnel_write)
		else $error("invalid marker on a multi-result packet");

endmodule

`default_nettype wire

### rtl/tunnel_replication_lookup_unit.sv
// top level of the tunnel replication lookup block
//
// Usage: drive the command fields and raise start; a transfer takes place at
// a rising edge with start high and busy low. Commands 1 to 4 write the iface
// map, tunnel map, call type and slot tables in that cycle and give no result;
// unknown commands are dropped. A packet (command 0) gives one to four
// results, each on the result ports for one cycle with done high and the
// final one marked by last.
// Flow: a packet passes the map reads, the call table read, the queue push
// and the result registers. The front holds busy per packet through the
// call table read and then the queue push, so it takes no new packet before
// it has pushed the last; the back emits one result per cycle from a
// two-entry queue while that queue holds a descriptor, and a packet waits in
// the front with busy high while that queue is full.
// Reset: control state clears at once, then a clearing pass zeroes the call
// type and slot tables, one call row per cycle, with busy high.
// The receiver cannot stall: results are strobed and never held.
`default_nettype none

module tunnel_replication_lookup_unit #(
	parameter int SLOTS   = 4,
	parameter int CALLS   = 1024,
	parameter int TUNNELS = 1024,
	parameter int IFACES  = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [2:0]                 command,
	input  wire logic                       rx_tunnel_valid,
	input  wire logic [trl_pkg::ID_W-1:0]   rx_tunnel,
	input  wire logic                       call_hint_valid,
	input  wire logic [trl_pkg::ID_W-1:0]   call_hint,
	input  wire logic [trl_pkg::ID_W-1:0]   tx_iface,
	input  wire logic [7:0]                 path_count,
	input  wire logic [7:0]                 path_slots,
	input  wire logic [trl_pkg::ID_W-1:0]   table_index,
	input  wire logic [1:0]                 slot_index,
	input  wire logic [trl_pkg::ID_W-1:0]   write_value,
	input  wire logic                       write_valid,
	output logic                            done,
	output logic                            tx_tunnel_write,
	output logic                            tx_tunnel_invalid,
	output logic [trl_pkg::ID_W-1:0]        tx_tunnel,
	output logic                            rx_iface_write,
	output logic                            is_duplicate,
	output logic                            last
);
	import trl_pkg::*;

	localparam int FW = $bits(trl_fixed_t);
	localparam int DW = SLOTS + SLOTS * ID_W + FW;

	logic                        q_full;
	logic                        q_empty;
	logic                        push;
	logic                        pop;
	logic [SLOTS-1:0]            desc_mask;
	logic [SLOTS-1:0][ID_W-1:0]  desc_tun;
	trl_fixed_t                  desc_fixed;
	logic [DW-1:0]               head;
	logic [SLOTS-1:0]            head_mask;
	logic [SLOTS-1:0][ID_W-1:0]  head_tun;
	trl_fixed_t                  head_fixed;

	// lookup and descriptor build
	trl_front #(
		.SLOTS   (SLOTS),
		.CALLS   (CALLS),
		.TUNNELS (TUNNELS),
		.IFACES  (IFACES)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.rx_tunnel_valid (rx_tunnel_valid),
		.rx_tunnel       (rx_tunnel),
		.call_hint_valid (call_hint_valid),
		.call_hint       (call_hint),
		.tx_iface        (tx_iface),
		.path_count      (path_count),
		.path_slots      (path_slots),
		.table_index     (table_index),
		.slot_index      (slot_index),
		.write_value     (write_value),
		.write_valid     (write_valid),
		.q_full          (q_full),
		.push            (push),
		.desc_mask       (desc_mask),
		.desc_tun        (desc_tun),
		.desc_fixed      (desc_fixed)
	);

	// descriptor queue
	trl_queue #(
		.WIDTH (DW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({desc_mask, desc_tun, desc_fixed}),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (head)
	);

	assign head_fixed = head[FW-1:0];
	assign head_tun   = head[FW +: SLOTS * ID_W];
	assign head_mask  = head[DW-1 -: SLOTS];

	// result walk
	trl_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_empty           (q_empty),
		.head_mask         (head_mask),
		.head_tun          (head_tun),
		.head_fixed        (head_fixed),
		.pop               (pop),
		.done              (done),
		.tx_tunnel_write   (tx_tunnel_write),
		.tx_tunnel_invalid (tx_tunnel_invalid),
		.tx_tunnel         (tx_tunnel),
		.rx_iface_write    (rx_iface_write),
		.is_duplicate      (is_duplicate),
		.last              (last)
	);

endmodule

`default_nettype wire
